>>> rtl/core/hex_length_frame_receiver_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the hex length frame receiver
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef HEX_LENGTH_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define HEX_LENGTH_FRAME_RECEIVER_UNIT_ASSERT_SVH

// Same-cycle implication
`define HLFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define HLFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/hlfr_pkg.sv
// ---------------------------------------------------------------------------
// hlfr_pkg
// Types, codes and helpers shared by the hex length frame receiver.
// ---------------------------------------------------------------------------
package hlfr_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned TICK_W   = 8;
  localparam int unsigned POS_W    = 3;
  localparam int unsigned NIB_W    = 4;
  localparam int unsigned STATUS_W = 2;

  localparam logic [TICK_W-1:0] TIMEOUT_RST = 8'd5;

  // header positions
  localparam logic [POS_W-1:0] POS_IDLE  = 3'd0;
  localparam logic [POS_W-1:0] POS_PRE1  = 3'd1;
  localparam logic [POS_W-1:0] POS_PRE2  = 3'd2;
  localparam logic [POS_W-1:0] POS_PRE3  = 3'd3;
  localparam logic [POS_W-1:0] POS_LENHI = 3'd4;
  localparam logic [POS_W-1:0] POS_LENLO = 3'd5;
  localparam logic [POS_W-1:0] POS_DATA  = 3'd6;

  // input kinds
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_PAYLOAD = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_PRE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd3;

  localparam logic [BYTE_W-1:0] CHR_F    = 8'h66;
  localparam logic [BYTE_W-1:0] CHR_E    = 8'h65;
  localparam logic [BYTE_W-1:0] CHR_0    = 8'h30;
  localparam logic [BYTE_W-1:0] CHR_9    = 8'h39;
  localparam logic [BYTE_W-1:0] CHR_A_LC = 8'h61;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [BYTE_W-1:0] rem;
    logic [TICK_W-1:0] ticks;
    logic              mis;
    logic [NIB_W-1:0]  hi;
  } hlfr_state_t;

  typedef struct packed {
    logic                vld;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   data;
    logic                last;
  } hlfr_result_t;

  // lower-case hex character to nibble, anything else gives 0
  function automatic logic [NIB_W-1:0] hex_digit(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] d;
    d = '0;
    if (c >= CHR_0 && c <= CHR_9) begin
      d = c - CHR_0;
    end else if (c >= CHR_A_LC && c <= CHR_F) begin
      d = c - CHR_A_LC + 8'd10;
    end
    return d[NIB_W-1:0];
  endfunction

endpackage

>>> rtl/core/hex_length_frame_receiver_unit.sv
// ---------------------------------------------------------------------------
// hex_length_frame_receiver_unit
// Frame receiver for "fffe" + two hex length digits + payload.
// ---------------------------------------------------------------------------
// Input channel in_*: one item per serial byte (in_tuser = 0, byte on
// in_tdata) or per time tick (in_tuser = 1). Result channel out_*: one item
// per payload byte (status 0, byte on out_tdata) or per frame event: empty
// frame, bad preamble, timeout (status 1..3, out_tdata = 0). out_tlast marks
// the final item of a frame or abort. Many input items give no result.
// cfg_wr_en/cfg_wr_data load the inter-byte timeout in ticks (reset 5); a
// new value is used from the next byte or frame end.
// The result passes through the input register, then the result register.
// Throughput: one item per cycle while the result side does not stall; the
// per-item state update is combinational logic.
// Reset clears both valid flags and the frame state; no setup is needed.
// When a result waits with out_tready low, the result register holds, the
// input register takes one more item if it is empty, then in_tready drops.
// ---------------------------------------------------------------------------
module hex_length_frame_receiver_unit
  import hlfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,    // [7:0] rx_byte
  input  logic              in_tuser,    // [0] op
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,   // [7:0] payload_byte
  output logic [1:0]        out_tuser,   // [1:0] status
  output logic              out_tlast,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data  // byte_timeout_ticks
);

  logic              in_vld_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              in_op_r;
  logic [TICK_W-1:0] timeout_r;
  hlfr_state_t       st_r;
  hlfr_state_t       st_nxt;
  hlfr_result_t      step_res;
  hlfr_result_t      out_r;
  logic              advance;

  assign advance   = in_vld_r && (!out_r.vld || out_tready);
  assign in_tready = !in_vld_r || advance;

  hlfr_step u_step (
    .cur     (st_r),
    .op      (in_op_r),
    .rx_byte (in_byte_r),
    .timeout (timeout_r),
    .nxt     (st_nxt),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_wr_en) begin
      timeout_r <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_op_r   <= in_tuser;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{pos: POS_IDLE, rem: '0, ticks: TIMEOUT_RST, mis: 1'b0, hi: '0};
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.vld <= 1'b0;
    end else if (advance) begin
      out_r.vld <= step_res.vld;
    end else if (out_tready) begin
      out_r.vld <= 1'b0;
    end
    if (advance && step_res.vld) begin
      out_r.status <= step_res.status;
      out_r.data   <= step_res.data;
      out_r.last   <= step_res.last;
    end
  end

  assign out_tvalid = out_r.vld;
  assign out_tdata  = out_r.data;
  assign out_tuser  = out_r.status;
  assign out_tlast  = out_r.last;

`include "hex_length_frame_receiver_unit_assert.svh"

  `HLFR_ASSERT_NOW(a_event_is_last, out_r.vld && out_r.status != ST_PAYLOAD, out_r.last, "frame event result without last")
  `HLFR_ASSERT_NEXT(a_last_ends_frame, advance && step_res.vld && step_res.last, st_r.pos == POS_IDLE, "frame state not cleared after last item")
  `HLFR_ASSERT_NEXT(a_in_hold, in_vld_r && !advance, in_vld_r && $stable(in_byte_r) && $stable(in_op_r), "buffered input item lost while stalled")
  `HLFR_ASSERT_NOW(a_mis_in_preamble, st_r.mis, st_r.pos == POS_PRE1 || st_r.pos == POS_PRE2 || st_r.pos == POS_PRE3, "preamble mismatch flag outside preamble")

endmodule

>>> rtl/core/hlfr_step.sv
// ---------------------------------------------------------------------------
// hlfr_step
// Next-state and result logic for one received byte or tick.
// ---------------------------------------------------------------------------
module hlfr_step
  import hlfr_pkg::*;
(
  input  hlfr_state_t       cur,
  input  logic              op,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic [TICK_W-1:0] timeout,
  output hlfr_state_t       nxt,
  output hlfr_result_t      res
);

  hlfr_state_t       clr;
  logic              mis_n;
  logic [BYTE_W-1:0] want;
  logic [BYTE_W-1:0] len;

  always_comb begin
    clr       = '0;
    clr.ticks = timeout;

    want  = (cur.pos == POS_PRE3) ? CHR_E : CHR_F;
    mis_n = cur.mis | (rx_byte != want);
    len   = {cur.hi, hex_digit(rx_byte)};

    nxt = cur;
    res = '0;

    if (op == OP_TICK) begin
      if (cur.pos != POS_IDLE) begin
        if (cur.ticks <= 8'd1) begin
          nxt        = clr;
          res.vld    = 1'b1;
          res.status = ST_TIMEOUT;
          res.last   = 1'b1;
        end else begin
          nxt.ticks = cur.ticks - 8'd1;
        end
      end
    end else begin
      nxt.ticks = timeout;
      unique case (cur.pos)
        POS_IDLE, POS_PRE1, POS_PRE2, POS_PRE3: begin
          if (cur.pos == POS_PRE3 && mis_n) begin
            nxt        = clr;
            res.vld    = 1'b1;
            res.status = ST_BAD_PRE;
            res.last   = 1'b1;
          end else begin
            nxt.pos = cur.pos + 3'd1;
            nxt.mis = mis_n;
          end
        end
        POS_LENHI: begin
          nxt.hi  = hex_digit(rx_byte);
          nxt.pos = POS_LENLO;
        end
        POS_LENLO: begin
          if (len == '0) begin
            nxt        = clr;
            res.vld    = 1'b1;
            res.status = ST_EMPTY;
            res.last   = 1'b1;
          end else begin
            nxt.pos = POS_DATA;
            nxt.rem = len;
          end
        end
        default: begin
          res.vld    = 1'b1;
          res.status = ST_PAYLOAD;
          res.data   = rx_byte;
          if (cur.rem <= 8'd1) begin
            nxt      = clr;
            res.last = 1'b1;
          end else begin
            nxt.rem = cur.rem - 8'd1;
          end
        end
      endcase
    end
  end

endmodule

>>> test/testbench.sv
// ---------------------------------------------------------------------------
// Hex length frame receiver testbench
// Streams received bytes and ticks into the receiver with bursty input
// timing and a stalling result side. An item-level predictor tracks
// preamble, length digits, payload count and the tick budget, and every
// result item is compared field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module testbench;
  import hlfr_pkg::*;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned PHASE_ITEMS = 310;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } rx_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] data;
    logic       last;
  } frame_result_t;

  typedef enum int unsigned {RDY_ALWAYS, RDY_HALF, RDY_SPARSE} ready_mode_e;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;
  logic       in_tuser = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;
  logic       out_tlast;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = '0;

  // predictor state
  logic [8:0] frame_pos;
  logic [8:0] bytes_left;
  logic [7:0] ticks_left;
  logic [7:0] timeout_cfg = TIMEOUT_RST;
  logic       pre_bad;
  logic [3:0] len_hi;

  rx_item_t      pending_items[$];
  frame_result_t expected_results[$];

  int unsigned items_pushed = 0;
  int unsigned items_taken = 0;
  int unsigned phase_items = 0;
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned gen_timeout = TIMEOUT_RST;
  bit          in_fire = 1'b0;

  // driver / receiver pacing
  rx_item_t    next_item;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned mode_left = 0;
  ready_mode_e rdy_mode = RDY_ALWAYS;

  hex_length_frame_receiver_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------- predictor ----------------

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if (c >= CHR_0 && c <= CHR_9) begin
      return 4'(c - CHR_0);
    end else if (c >= CHR_A_LC && c <= CHR_F) begin
      return 4'(c - CHR_A_LC + 8'd10);
    end
    return 4'd0;
  endfunction

  function automatic void clear_frame();
    frame_pos  = '0;
    bytes_left = 9'd261;
    ticks_left = timeout_cfg;
    pre_bad    = 1'b0;
    len_hi     = '0;
  endfunction

  task automatic predict_item(input logic op, input logic [7:0] c);
    frame_result_t r;
    logic [8:0]    len;
    r = '0;
    r.last = 1'b1;
    if (op == OP_TICK) begin
      if (frame_pos != 0) begin
        if (ticks_left <= 8'd1) begin
          clear_frame();
          r.status = ST_TIMEOUT;
          expected_results.push_back(r);
        end else begin
          ticks_left = ticks_left - 8'd1;
        end
      end
    end else begin
      ticks_left = timeout_cfg;
      if (frame_pos < 4) begin
        if (c != ((frame_pos == 3) ? CHR_E : CHR_F)) pre_bad = 1'b1;
        frame_pos  = frame_pos + 9'd1;
        bytes_left = bytes_left - 9'd1;
        if (frame_pos == 4 && pre_bad) begin
          clear_frame();
          r.status = ST_BAD_PRE;
          expected_results.push_back(r);
        end
      end else if (frame_pos == 4) begin
        len_hi     = nibble_of(c);
        frame_pos  = 9'd5;
        bytes_left = bytes_left - 9'd1;
      end else if (frame_pos == 5) begin
        len = {1'b0, len_hi, nibble_of(c)};
        if (len == 0) begin
          clear_frame();
          r.status = ST_EMPTY;
          expected_results.push_back(r);
        end else begin
          frame_pos  = 9'd6;
          bytes_left = len;
        end
      end else begin
        r.status = ST_PAYLOAD;
        r.data   = c;
        if (bytes_left <= 9'd1) begin
          clear_frame();
        end else begin
          bytes_left = bytes_left - 9'd1;
          frame_pos  = frame_pos + 9'd1;
          r.last     = 1'b0;
        end
        expected_results.push_back(r);
      end
    end
  endtask

  // ---------------- driver ----------------

  always @(negedge clk) begin
    if (rst_n && !(in_tvalid && !in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        next_item = pending_items.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= next_item.op;
        in_tdata  <= next_item.data;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result side: changing ready patterns plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rdy_mode  = ready_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      case (rdy_mode)
        RDY_ALWAYS: out_tready <= 1'b1;
        RDY_HALF:   out_tready <= 1'($urandom_range(0, 1));
        default:    out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ---------------- monitor / checker ----------------

  always @(posedge clk) begin
    frame_result_t exp_r;
    in_fire = in_tvalid && in_tready;
    if (rst_n) begin
      if (in_fire) begin
        predict_item(in_tuser, in_tdata);
        items_taken++;
      end
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: status %0d data %0h last %0b",
                 out_tuser, out_tdata, out_tlast);
          error_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_tuser !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, out_tuser);
            error_count++;
          end
          if (out_tdata !== exp_r.data) begin
            $error("payload_byte: expected %0h, got %0h", exp_r.data, out_tdata);
            error_count++;
          end
          if (out_tlast !== exp_r.last) begin
            $error("last: expected %0b, got %0b", exp_r.last, out_tlast);
            error_count++;
          end
        end
      end
      if (in_fire || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  // ---------------- stimulus ----------------

  task automatic add_byte(input logic [7:0] b);
    pending_items.push_back('{op: OP_BYTE, data: b});
    items_pushed++;
    phase_items++;
  endtask

  task automatic add_ticks(input int unsigned n);
    repeat (n) begin
      pending_items.push_back('{op: OP_TICK, data: 8'($urandom_range(0, 255))});
      items_pushed++;
      phase_items++;
    end
  endtask

  function automatic int unsigned abort_ticks();
    return (gen_timeout == 0) ? 1 : gen_timeout;
  endfunction

  function automatic logic [7:0] hex_char(input int unsigned n);
    return (n < 10) ? CHR_0 + 8'(n) : CHR_A_LC + 8'(n - 10);
  endfunction

  // ticks between bytes: mostly none, sometimes one or two, sometimes right at the budget edge
  task automatic add_gap();
    int unsigned pick;
    pick = $urandom_range(0, 999);
    if (pick >= 850 && pick < 970) begin
      add_ticks((gen_timeout > 2) ? $urandom_range(1, 2) : 0);
    end else if (pick >= 970 && (gen_timeout <= 16 || pick >= 995)) begin
      if (pick % 2 == 0) add_ticks(abort_ticks());
      else if (gen_timeout >= 2) add_ticks(gen_timeout - 1);
    end
  endtask

  task automatic add_frame(input bit raw_len);
    int unsigned len, pick, k;
    logic [7:0]  hi_c, lo_c;
    pick = $urandom_range(0, 99);
    if (pick < 70) len = $urandom_range(0, 12);
    else if (pick < 96) len = $urandom_range(13, 60);
    else if (pick < 99) len = $urandom_range(61, 254);
    else len = 255;
    if (raw_len) begin
      hi_c = 8'($urandom_range(0, 255));
      lo_c = 8'($urandom_range(0, 255));
      len  = nibble_of(hi_c) * 16 + nibble_of(lo_c);
    end else begin
      hi_c = hex_char(len / 16);
      lo_c = hex_char(len % 16);
    end
    for (k = 0; k < 4; k++) begin
      add_byte((k == 3) ? CHR_E : CHR_F);
      add_gap();
    end
    add_byte(hi_c);
    add_gap();
    add_byte(lo_c);
    for (k = 0; k < len; k++) begin
      add_gap();
      add_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic add_noise();
    int unsigned n, k, bad;
    case ($urandom_range(0, 4))
      0: begin
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++) add_byte(8'($urandom_range(0, 255)));
      end
      1: begin
        bad = $urandom_range(0, 3);
        for (k = 0; k < 4; k++) begin
          if (k == bad) add_byte(8'($urandom_range(0, 255)));
          else add_byte((k == 3) ? CHR_E : CHR_F);
        end
      end
      2: begin
        // frame cut short, then left to time out
        n = $urandom_range(1, 9);
        for (k = 0; k < n; k++) begin
          if (k < 3) add_byte(CHR_F);
          else if (k == 3) add_byte(CHR_E);
          else if (k == 4) add_byte(CHR_0);
          else if (k == 5) add_byte(CHR_F);
          else add_byte(8'($urandom_range(0, 255)));
        end
        add_ticks(abort_ticks());
      end
      3: add_frame(1'b1);
      default: add_ticks($urandom_range(1, 3));
    endcase
  endtask

  task automatic wait_drained();
    while (items_taken != items_pushed || expected_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic set_timeout(input logic [7:0] t);
    wait_drained();
    // items without a result may still be in the two-stage pipe
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= t;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    timeout_cfg = t;
    gen_timeout = t;
  endtask

  initial begin
    logic [7:0] timeouts [6];
    int unsigned p;
    clear_frame();

    // directed part, runs on the reset timeout of 5
    add_ticks(1);
    add_byte(CHR_F); add_byte(CHR_F); add_byte(CHR_F); add_byte(CHR_E);
    add_byte(CHR_0); add_byte(CHR_0);
    add_byte(8'h00); add_byte(CHR_F); add_byte(CHR_F); add_byte(CHR_E);
    add_byte(CHR_F); add_byte(CHR_F); add_byte(CHR_F); add_byte(CHR_E);
    add_byte(8'h67); add_byte(8'h31); add_byte(8'hff);
    add_byte(CHR_F);
    add_ticks(5);

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    timeouts[0] = 8'd1;
    timeouts[1] = 8'd255;
    timeouts[2] = 8'd0;
    timeouts[3] = 8'($urandom_range(2, 8));
    timeouts[4] = 8'($urandom_range(9, 254));
    timeouts[5] = TIMEOUT_RST;

    for (p = 0; p < 6; p++) begin
      set_timeout(timeouts[p]);
      if (p == 0) hold_req = 1'b1;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 85) add_frame(1'b0);
        else add_noise();
      end
    end

    wait_drained();
    repeat (10) @(negedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
